// ===== rtl/bmca_pkg.sv =====
// Shared types, codes and helpers for the Barrett modular coefficient ALU.
// Used by bmca_mul64 and barrett_modular_coefficient_alu; depends on nothing.
`default_nettype none

package bmca_pkg;

  localparam int unsigned WORD_W      = 64;
  localparam int unsigned COEF_W      = 61;
  localparam int unsigned IN_TDATA_W  = 128;
  localparam int unsigned OUT_TDATA_W = 64;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned NUM_STAGES  = 9;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [COEF_W-1:0] coef_t;

  typedef enum logic [1:0] {
    FUNC_ADD = 2'd0,
    FUNC_SUB = 2'd1,
    FUNC_MUL = 2'd2,
    FUNC_RED = 2'd3
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODULUS  = 2'd0,
    CFG_RATIO_LO = 2'd1,
    CFG_RATIO_HI = 2'd2
  } cfg_idx_t;

  localparam coef_t MODULUS_RST  = 61'd2;
  localparam word_t RATIO_LO_RST = 64'd0;
  localparam word_t RATIO_HI_RST = 64'h8000_0000_0000_0000;

  // Sideband that travels with each item down the pipeline
  typedef struct packed {
    func_t func;
    logic  err;
    logic  last;
  } ctl_t;

  // Four 32x32 partial products of a 64x64 multiply
  typedef struct packed {
    word_t ll;
    word_t lh;
    word_t hl;
    word_t hh;
  } pp_t;

  function automatic logic [2*WORD_W-1:0] pp_sum(pp_t p);
    return {64'd0, p.ll} + {32'd0, p.lh, 32'd0} + {32'd0, p.hl, 32'd0} + {p.hh, 64'd0};
  endfunction

  // Low word only of the full product
  function automatic word_t pp_lo(pp_t p);
    return p.ll + {p.lh[31:0], 32'd0} + {p.hl[31:0], 32'd0};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/barrett_modular_coefficient_alu.sv =====
// Barrett modular coefficient ALU: nine-stage pipeline, one item per cycle while
// out_tready holds; the throughput is set by the registered 32x32 partial-product
// stages, so a new item can enter while earlier ones are still in flight.
// Each stage advances on its own, so bubbles close up under output back-pressure.
// Reset (rst_n low, synchronous) empties the pipeline and loads q = 2, ratio 2^127.
// Depends on bmca_pkg and bmca_mul64.
`default_nettype none

module barrett_modular_coefficient_alu (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_tvalid,
  output logic                                       in_tready,
  // [63:0] operand_a, [124:64] operand_b, [127:125] zero
  input  wire logic [bmca_pkg::IN_TDATA_W-1:0]       in_tdata,
  // [1:0] func
  input  wire logic [1:0]                            in_tuser,
  input  wire logic                                  in_tlast,
  output logic                                       out_tvalid,
  input  wire logic                                  out_tready,
  // [60:0] result_value, [63:61] zero
  output logic [bmca_pkg::OUT_TDATA_W-1:0]           out_tdata,
  // [0] operand_error
  output logic                                       out_tuser,
  output logic                                       out_tlast,
  input  wire logic                                  cfg_wr_en,
  input  wire logic [bmca_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [bmca_pkg::WORD_W-1:0]           cfg_wdata
);
  import bmca_pkg::*;

  // Configuration
  coef_t mod_r, mod_nxt;
  word_t rlo_r, rlo_nxt;
  word_t rhi_r, rhi_nxt;
  word_t mod_w;

  always_comb begin
    mod_nxt = mod_r;
    rlo_nxt = rlo_r;
    rhi_nxt = rhi_r;
    if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_MODULUS:  mod_nxt = cfg_wdata[COEF_W-1:0];
        CFG_RATIO_LO: rlo_nxt = cfg_wdata;
        CFG_RATIO_HI: rhi_nxt = cfg_wdata;
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r <= MODULUS_RST;
      rlo_r <= RATIO_LO_RST;
      rhi_r <= RATIO_HI_RST;
    end else begin
      mod_r <= mod_nxt;
      rlo_r <= rlo_nxt;
      rhi_r <= rhi_nxt;
    end
  end

  assign mod_w = {3'd0, mod_r};

  // Stage control: each stage loads when empty or when the next one moves on
  logic [NUM_STAGES:1]   vld_r, vld_nxt;
  logic [NUM_STAGES+1:1] en;
  logic [NUM_STAGES-1:0] vin;

  always_comb begin
    en[NUM_STAGES+1] = out_tready;
    for (int k = NUM_STAGES; k >= 1; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
    vin = {vld_r[NUM_STAGES-1:1], in_tvalid};
    for (int k = 1; k <= NUM_STAGES; k++) begin
      vld_nxt[k] = en[k] ? vin[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_tready = en[1];

  // Stage 1: operand product, range check
  word_t a_in;
  coef_t b_in;
  func_t f_in;
  logic  err_in;
  word_t a1_r;
  coef_t b1_r;
  ctl_t  ctl1_r;
  pp_t   pp_ab;

  assign a_in   = in_tdata[WORD_W-1:0];
  assign b_in   = in_tdata[WORD_W+COEF_W-1:WORD_W];
  assign f_in   = func_t'(in_tuser);
  assign err_in = (f_in != FUNC_RED) && ((a_in >= mod_w) || (b_in >= mod_r));

  bmca_mul64 u_mul_ab (
    .clk (clk),
    .en  (en[1]),
    .x   (a_in),
    .y   ({3'd0, b_in}),
    .pp  (pp_ab)
  );

  always_ff @(posedge clk) begin
    if (en[1]) begin
      a1_r   <= a_in;
      b1_r   <= b_in;
      ctl1_r <= '{func: f_in, err: err_in, last: in_tlast};
    end
  end

  // Stage 2: product words, raw sum and difference
  logic [2*WORD_W-1:0] prod2;
  word_t               zl2_r, zh2_r;
  logic [WORD_W:0]     sum2_r, dif2_r;
  ctl_t                ctl2_r;

  assign prod2 = pp_sum(pp_ab);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      // reduce takes operand_a through the same low-word path
      zl2_r  <= (ctl1_r.func == FUNC_RED) ? a1_r : prod2[WORD_W-1:0];
      zh2_r  <= prod2[2*WORD_W-1:WORD_W];
      sum2_r <= {1'b0, a1_r} + {4'd0, b1_r};
      dif2_r <= {1'b0, a1_r} - {4'd0, b1_r};
      ctl2_r <= ctl1_r;
    end
  end

  // Stage 3: ratio partial products, add/subtract correction
  pp_t   pp_lr, pp_lh, pp_hl, pp_hh;
  word_t as_w;
  word_t zl3_r;
  coef_t as3_r;
  ctl_t  ctl3_r;

  bmca_mul64 u_mul_lr (.clk(clk), .en(en[3]), .x(zl2_r), .y(rlo_r), .pp(pp_lr));
  bmca_mul64 u_mul_lh (.clk(clk), .en(en[3]), .x(zl2_r), .y(rhi_r), .pp(pp_lh));
  bmca_mul64 u_mul_hl (.clk(clk), .en(en[3]), .x(zh2_r), .y(rlo_r), .pp(pp_hl));
  bmca_mul64 u_mul_hh (.clk(clk), .en(en[3]), .x(zh2_r), .y(rhi_r), .pp(pp_hh));

  always_comb begin
    case (ctl2_r.func)
      FUNC_ADD: as_w = (sum2_r >= {1'b0, mod_w}) ? sum2_r[WORD_W-1:0] - mod_w
                                                 : sum2_r[WORD_W-1:0];
      FUNC_SUB: as_w = dif2_r[WORD_W-1:0] + (dif2_r[WORD_W] ? mod_w : '0);
      default:  as_w = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      zl3_r  <= zl2_r;
      as3_r  <= as_w[COEF_W-1:0];
      ctl3_r <= ctl2_r;
    end
  end

  // Stage 4: sum the ratio partial products
  logic [2*WORD_W-1:0] plr4, p1_4_r, p2_4_r;
  word_t               c1_4_r, l4_r, zl4_r;
  coef_t               as4_r;
  ctl_t                ctl4_r;

  assign plr4 = pp_sum(pp_lr);

  always_ff @(posedge clk) begin
    if (en[4]) begin
      c1_4_r <= plr4[2*WORD_W-1:WORD_W];
      p1_4_r <= pp_sum(pp_lh);
      p2_4_r <= pp_sum(pp_hl);
      l4_r   <= pp_lo(pp_hh);
      zl4_r  <= zl3_r;
      as4_r  <= as3_r;
      ctl4_r <= ctl3_r;
    end
  end

  // Stage 5: round one carry, partial estimate
  logic [WORD_W:0] s5_w;
  word_t           s5_r, hi3_5_r, t5_r, pl2_5_r, estr5_r, zl5_r;
  coef_t           as5_r;
  ctl_t            ctl5_r;

  assign s5_w = {1'b0, p1_4_r[WORD_W-1:0]} + {1'b0, c1_4_r};

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_r    <= s5_w[WORD_W-1:0];
      hi3_5_r <= p1_4_r[2*WORD_W-1:WORD_W] + word_t'(s5_w[WORD_W]);
      t5_r    <= l4_r + p2_4_r[2*WORD_W-1:WORD_W];
      pl2_5_r <= p2_4_r[WORD_W-1:0];
      estr5_r <= p1_4_r[2*WORD_W-1:WORD_W];
      zl5_r   <= zl4_r;
      as5_r   <= as4_r;
      ctl5_r  <= ctl4_r;
    end
  end

  // Stage 6: round two carry, quotient estimate
  logic [WORD_W:0] s6_w;
  word_t           est6_r, zl6_r;
  coef_t           as6_r;
  ctl_t            ctl6_r;

  assign s6_w = {1'b0, s5_r} + {1'b0, pl2_5_r};

  always_ff @(posedge clk) begin
    if (en[6]) begin
      est6_r <= (ctl5_r.func == FUNC_RED) ? estr5_r
                                          : t5_r + hi3_5_r + word_t'(s6_w[WORD_W]);
      zl6_r  <= zl5_r;
      as6_r  <= as5_r;
      ctl6_r <= ctl5_r;
    end
  end

  // Stage 7: estimate times modulus
  pp_t   pp_eq;
  word_t zl7_r;
  coef_t as7_r;
  ctl_t  ctl7_r;

  bmca_mul64 u_mul_eq (.clk(clk), .en(en[7]), .x(est6_r), .y(mod_w), .pp(pp_eq));

  always_ff @(posedge clk) begin
    if (en[7]) begin
      zl7_r  <= zl6_r;
      as7_r  <= as6_r;
      ctl7_r <= ctl6_r;
    end
  end

  // Stage 8: remainder before correction
  word_t t8_r;
  coef_t as8_r;
  ctl_t  ctl8_r;

  always_ff @(posedge clk) begin
    if (en[8]) begin
      t8_r   <= zl7_r - pp_lo(pp_eq);
      as8_r  <= as7_r;
      ctl8_r <= ctl7_r;
    end
  end

  // Stage 9: final subtract and result select (output register)
  word_t rem9_w;
  coef_t res9_w;
  coef_t res9_r;
  ctl_t  ctl9_r;

  assign rem9_w = (t8_r >= mod_w) ? t8_r - mod_w : t8_r;

  always_comb begin
    if (ctl8_r.err) begin
      res9_w = '0;
    end else begin
      case (ctl8_r.func)
        FUNC_ADD, FUNC_SUB: res9_w = as8_r;
        default:            res9_w = rem9_w[COEF_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en[9]) begin
      res9_r <= res9_w;
      ctl9_r <= ctl8_r;
    end
  end

  assign out_tvalid = vld_r[NUM_STAGES];
  assign out_tdata  = {3'd0, res9_r};
  assign out_tuser  = ctl9_r.err;
  assign out_tlast  = ctl9_r.last;

  // Checks
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (&vld_r) && !out_tready)
    else $error("input stalled with a free pipeline stage");

  a_err_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("operand error with non-zero result");

  a_reduce_no_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (ctl9_r.func == FUNC_RED) |-> !ctl9_r.err)
    else $error("reduce flagged an operand error");

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[NUM_STAGES] && !out_tready |=> vld_r[NUM_STAGES] && $stable(res9_r))
    else $error("waiting result lost or changed");

endmodule

`default_nettype wire

// ===== rtl/bmca_mul64.sv =====
// Registered 64x64 partial-product stage: four 32x32 products per cycle while en is high.
// Depends on bmca_pkg for word_t and pp_t.
`default_nettype none

module bmca_mul64 (
  input  wire logic           clk,
  input  wire logic           en,
  input  wire bmca_pkg::word_t x,
  input  wire bmca_pkg::word_t y,
  output bmca_pkg::pp_t        pp
);
  import bmca_pkg::*;

  pp_t pp_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pp_r.ll <= 64'(x[31:0])  * 64'(y[31:0]);
      pp_r.lh <= 64'(x[31:0])  * 64'(y[63:32]);
      pp_r.hl <= 64'(x[63:32]) * 64'(y[31:0]);
      pp_r.hh <= 64'(x[63:32]) * 64'(y[63:32]);
    end
  end

  assign pp = pp_r;

endmodule

`default_nettype wire
